@@ rtl/core/pps_pkg.sv @@
// shared types and constants of the priority scheduler
package pps_pkg;

   localparam int ID_W    = 8;
   localparam int PRIO_W  = 8;
   localparam int BURST_W = 16;
   localparam int TIME_W  = 32;
   localparam int KIND_W  = 3;

   localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_IDLE     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RUNNING  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FINISHED = 3'd4;

   localparam logic FUNC_ARRIVAL = 1'b0;
   localparam logic FUNC_TICK    = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] left;
      logic [BURST_W-1:0] total;
      logic [TIME_W-1:0]  arrived;
      logic [TIME_W-1:0]  resp;
      logic               started;
   } slot_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_REJECT,
      OP_IDLE,
      OP_ARR_INIT,
      OP_READ_TOP,
      OP_TAKE_TOP,
      OP_READ_KIDS,
      OP_DOWN_STEP,
      OP_WRITE_CARRIED,
      OP_REINSERT,
      OP_FINISH,
      OP_READ_PARENT,
      OP_UP_STEP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rsp_load;
   } cmd_type;

   typedef struct packed {
      logic func;
      logic full;
      logic empty;
      logic cnt_ge2;
      logic pos_zero;
      logic up_swap;
      logic down_move;
      logic more_work;
   } status_type;

endpackage

@@ rtl/core/pps_ctrl.sv @@
// sequencer of the priority scheduler
module pps_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  pps_pkg::status_type status,
   output pps_pkg::cmd_type    cmd
);
   import pps_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_TOP, S_DN_RD, S_DN_CMP, S_AFTER, S_UP_CHK, S_UP_CMP, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.rsp_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_ACCEPT;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.func == FUNC_ARRIVAL) begin
               if (status.full) begin
                  cmd.op   = OP_REJECT;
                  state_in = S_DONE;
               end else begin
                  cmd.op   = OP_ARR_INIT;
                  state_in = S_UP_CHK;
               end
            end else if (status.empty) begin
               cmd.op   = OP_IDLE;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_READ_TOP;
               state_in = S_TOP;
            end
         end
         S_TOP: begin
            cmd.op   = OP_TAKE_TOP;
            state_in = status.cnt_ge2 ? S_DN_RD : S_AFTER;
         end
         S_DN_RD: begin
            cmd.op   = OP_READ_KIDS;
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (status.down_move) begin
               cmd.op   = OP_DOWN_STEP;
               state_in = S_DN_RD;
            end else begin
               cmd.op   = OP_WRITE_CARRIED;
               state_in = S_AFTER;
            end
         end
         S_AFTER: begin
            if (status.more_work) begin
               cmd.op   = OP_REINSERT;
               state_in = S_UP_CHK;
            end else begin
               cmd.op   = OP_FINISH;
               state_in = S_DONE;
            end
         end
         S_UP_CHK: begin
            if (status.pos_zero) begin
               cmd.op   = OP_WRITE_CARRIED;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_READ_PARENT;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (status.up_swap) begin
               cmd.op   = OP_UP_STEP;
               state_in = S_UP_CHK;
            end else begin
               cmd.op   = OP_WRITE_CARRIED;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

@@ rtl/core/pps_dpath.sv @@
// heap memory, working registers and result register of the scheduler
module pps_dpath #(
   parameter int HEAP_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pps_pkg::cmd_type              cmd,
   output pps_pkg::status_type           status,
   input  logic                          in_func,
   input  logic [pps_pkg::ID_W-1:0]      in_id,
   input  logic [pps_pkg::PRIO_W-1:0]    in_prio,
   input  logic [pps_pkg::BURST_W-1:0]   in_burst,
   output logic [pps_pkg::KIND_W-1:0]    out_kind,
   output logic [pps_pkg::ID_W-1:0]      out_id,
   output logic [pps_pkg::TIME_W-1:0]    out_stamp,
   output logic [pps_pkg::TIME_W-1:0]    out_resp,
   output logic [pps_pkg::TIME_W-1:0]    out_wait,
   output logic [pps_pkg::TIME_W-1:0]    out_turn
);
   import pps_pkg::*;

   localparam int IDX_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
   localparam int KID_W = IDX_W + 2;

   slot_type mem [HEAP_DEPTH];
   slot_type rda_ff, rdb_ff;
   logic     mem_we;
   logic [IDX_W-1:0] wa, ra, rb;
   slot_type wd;

   logic            func_ff;
   logic [ID_W-1:0] id_ff;
   logic [PRIO_W-1:0] prio_ff;
   logic [BURST_W-1:0] burst_ff;
   logic [CNT_W-1:0] count_ff;
   logic [TIME_W-1:0] time_ff, stamp_ff;
   logic [IDX_W-1:0] pos_ff;
   slot_type carried_ff, m_ff, top_slot, again_slot;

   logic [KIND_W-1:0] kind_ff;
   logic [ID_W-1:0]   ran_ff;
   logic [TIME_W-1:0] resp_ff, wait_ff, turn_ff, turn_calc;

   logic [KID_W-1:0] kid_l, kid_r, cnt_x;
   logic [IDX_W-1:0] parent, best_idx;
   logic             l_ok, r_ok, sel_l, sel_r;
   logic [PRIO_W-1:0] best_prio;

   assign kid_l  = {1'b0, pos_ff, 1'b1};
   assign kid_r  = {pos_ff, 1'b0} + KID_W'(2);
   assign cnt_x  = KID_W'(count_ff);
   assign parent = (pos_ff - IDX_W'(1)) >> 1;
   assign l_ok   = kid_l < cnt_x;
   assign r_ok   = kid_r < cnt_x;

   always_comb begin
      sel_l     = 1'b0;
      sel_r     = 1'b0;
      best_prio = carried_ff.prio;
      if (l_ok && (rda_ff.prio < best_prio)) begin
         sel_l     = 1'b1;
         best_prio = rda_ff.prio;
      end
      if (r_ok && (rdb_ff.prio < best_prio)) begin
         sel_r = 1'b1;
      end
      best_idx = sel_r ? kid_r[IDX_W-1:0] : kid_l[IDX_W-1:0];
   end

   always_comb begin
      top_slot = rda_ff;
      if (!rda_ff.started) begin
         top_slot.resp    = stamp_ff - rda_ff.arrived;
         top_slot.started = 1'b1;
      end
   end

   always_comb begin
      again_slot      = m_ff;
      again_slot.left = m_ff.left - BURST_W'(1);
   end

   assign turn_calc = (stamp_ff + TIME_W'(1)) - m_ff.arrived;

   assign status.func      = func_ff;
   assign status.full      = (count_ff == CNT_W'(HEAP_DEPTH));
   assign status.empty     = (count_ff == '0);
   assign status.cnt_ge2   = (count_ff >= CNT_W'(2));
   assign status.pos_zero  = (pos_ff == '0);
   assign status.up_swap   = (rda_ff.prio > carried_ff.prio);
   assign status.down_move = sel_l || sel_r;
   assign status.more_work = (m_ff.left > BURST_W'(1));

   always_comb begin
      mem_we = 1'b0;
      wa     = pos_ff;
      wd     = carried_ff;
      ra     = '0;
      rb     = IDX_W'(count_ff - CNT_W'(1));
      case (cmd.op)
         OP_READ_KIDS: begin
            ra = kid_l[IDX_W-1:0];
            rb = kid_r[IDX_W-1:0];
         end
         OP_READ_PARENT: begin
            ra = parent;
         end
         OP_DOWN_STEP: begin
            mem_we = 1'b1;
            wd     = sel_r ? rdb_ff : rda_ff;
         end
         OP_UP_STEP: begin
            mem_we = 1'b1;
            wd     = rda_ff;
         end
         OP_WRITE_CARRIED: begin
            mem_we = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wa] <= wd;
      end
      rda_ff <= mem[ra];
      rdb_ff <= mem[rb];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         time_ff  <= '0;
      end else begin
         case (cmd.op)
            OP_ACCEPT: begin
               if (in_func == FUNC_TICK) begin
                  time_ff <= time_ff + TIME_W'(1);
               end
            end
            OP_ARR_INIT: count_ff <= count_ff + CNT_W'(1);
            OP_TAKE_TOP: count_ff <= count_ff - CNT_W'(1);
            OP_REINSERT: count_ff <= count_ff + CNT_W'(1);
            default: begin
               count_ff <= count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_ACCEPT: begin
            func_ff  <= in_func;
            id_ff    <= in_id;
            prio_ff  <= in_prio;
            burst_ff <= in_burst;
            stamp_ff <= time_ff;
            resp_ff  <= '0;
            wait_ff  <= '0;
            turn_ff  <= '0;
         end
         OP_REJECT: begin
            kind_ff <= KIND_REJECTED;
            ran_ff  <= id_ff;
         end
         OP_IDLE: begin
            kind_ff <= KIND_IDLE;
            ran_ff  <= '0;
         end
         OP_ARR_INIT: begin
            kind_ff            <= KIND_ACCEPTED;
            ran_ff             <= id_ff;
            pos_ff             <= IDX_W'(count_ff);
            carried_ff.id      <= id_ff;
            carried_ff.prio    <= prio_ff;
            carried_ff.left    <= burst_ff;
            carried_ff.total   <= burst_ff;
            carried_ff.arrived <= stamp_ff;
            carried_ff.resp    <= '0;
            carried_ff.started <= 1'b0;
         end
         OP_TAKE_TOP: begin
            m_ff       <= top_slot;
            carried_ff <= rdb_ff;
            pos_ff     <= '0;
         end
         OP_DOWN_STEP: begin
            pos_ff <= best_idx;
         end
         OP_UP_STEP: begin
            pos_ff <= parent;
         end
         OP_REINSERT: begin
            kind_ff    <= KIND_RUNNING;
            ran_ff     <= m_ff.id;
            pos_ff     <= IDX_W'(count_ff);
            carried_ff <= again_slot;
         end
         OP_FINISH: begin
            kind_ff <= KIND_FINISHED;
            ran_ff  <= m_ff.id;
            resp_ff <= m_ff.resp;
            turn_ff <= turn_calc;
            wait_ff <= turn_calc - TIME_W'(m_ff.total);
         end
         default: begin
            pos_ff <= pos_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         out_kind  <= kind_ff;
         out_id    <= ran_ff;
         out_stamp <= stamp_ff;
         out_resp  <= resp_ff;
         out_wait  <= wait_ff;
         out_turn  <= turn_ff;
      end
   end

endmodule

@@ rtl/core/preemptive_priority_scheduler_unit.sv @@
// top level of the preemptive priority scheduler
// a reject or idle tick is decided at decode; an arrival climbs the heap from the last slot,
// a tick takes the top, sifts the last entry down when two or more were queued, and then
// reinserts the job and climbs when work remains, else reports it finished
// one item in flight, set by the heap memory walked one level at a time
// reset clears entry count, time and handshake state; heap memory is not cleared
module preemptive_priority_scheduler_unit #(
   parameter int HEAP_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,  // proc_id, prio, burst
   input  logic         req_tuser,  // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,  // ran_id, stamp, resp_time, wait_time, turnaround
   output logic [2:0]   rsp_tuser   // kind
);
   import pps_pkg::*;

   cmd_type    cmd;
   status_type status;

   pps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pps_dpath #(.HEAP_DEPTH(HEAP_DEPTH)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_func   (req_tuser),
      .in_id     (req_tdata[7:0]),
      .in_prio   (req_tdata[15:8]),
      .in_burst  (req_tdata[31:16]),
      .out_kind  (rsp_tuser),
      .out_id    (rsp_tdata[7:0]),
      .out_stamp (rsp_tdata[39:8]),
      .out_resp  (rsp_tdata[71:40]),
      .out_wait  (rsp_tdata[103:72]),
      .out_turn  (rsp_tdata[135:104])
   );

endmodule

@@ rtl/core/pps_checker.sv @@
// port checks of the priority scheduler and their binding
module pps_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic [2:0]   rsp_tuser
);
   import pps_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= KIND_FINISHED)
      else $error("result kind out of range");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while busy");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_IDLE |-> rsp_tdata[7:0] == '0 && rsp_tdata[71:40] == '0)
      else $error("idle tick carries data");

endmodule

bind preemptive_priority_scheduler_unit pps_checker u_pps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ dv/testbench.sv @@
// self-checking testbench of the preemptive priority scheduler unit
`timescale 1ns / 100ps

module testbench;
   import pps_pkg::*;

   localparam int DEPTH = 16;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   ran_id;
      logic [TIME_W-1:0] stamp;
      logic [TIME_W-1:0] resp_time;
      logic [TIME_W-1:0] wait_time;
      logic [TIME_W-1:0] turnaround;
   } outcome_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic [2:0]   rsp_tuser;

   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  hold_off = 0;
   int  failures = 0;
   int  quiet_cycles = 0;
   outcome_type expected_outcomes[$];

   // predictor state
   slot_type    ready_heap[DEPTH];
   int          ready_count = 0;
   logic [31:0] sched_time = '0;

   preemptive_priority_scheduler_unit #(.HEAP_DEPTH(DEPTH)) DUT (.*);

   always #5 clock = ~clock;

   function automatic void heap_push(slot_type s);
      int pos;
      int parent;
      slot_type t;
      pos = ready_count;
      ready_heap[pos] = s;
      ready_count++;
      while (pos != 0) begin
         parent = (pos - 1) / 2;
         if (ready_heap[parent].prio > ready_heap[pos].prio) begin
            t = ready_heap[parent];
            ready_heap[parent] = ready_heap[pos];
            ready_heap[pos] = t;
            pos = parent;
         end else begin
            break;
         end
      end
   endfunction

   function automatic void heap_sift_down();
      int pos;
      int best;
      slot_type t;
      pos = 0;
      forever begin
         best = pos;
         if (2*pos+1 < ready_count && ready_heap[2*pos+1].prio < ready_heap[best].prio)
            best = 2*pos+1;
         if (2*pos+2 < ready_count && ready_heap[2*pos+2].prio < ready_heap[best].prio)
            best = 2*pos+2;
         if (best == pos) break;
         t = ready_heap[best];
         ready_heap[best] = ready_heap[pos];
         ready_heap[pos] = t;
         pos = best;
      end
   endfunction

   function automatic outcome_type schedule_item(logic func, logic [7:0] pid,
                                                 logic [7:0] prio, logic [15:0] burst);
      outcome_type o;
      slot_type s;
      logic [31:0] turn;
      o = '{KIND_ACCEPTED, '0, sched_time, '0, '0, '0};
      if (func == FUNC_ARRIVAL) begin
         o.ran_id = pid;
         if (ready_count >= DEPTH) begin
            o.kind = KIND_REJECTED;
         end else begin
            s = '{pid, prio, burst, burst, sched_time, '0, 1'b0};
            heap_push(s);
         end
      end else begin
         if (ready_count == 0) begin
            o.kind = KIND_IDLE;
         end else begin
            s = ready_heap[0];
            if (!s.started) begin
               s.resp = sched_time - s.arrived;
               s.started = 1'b1;
            end
            ready_count--;
            if (ready_count >= 1) begin
               ready_heap[0] = ready_heap[ready_count];
               heap_sift_down();
            end
            o.ran_id = s.id;
            if (s.left > 16'd1) begin
               s.left = s.left - 16'd1;
               heap_push(s);
               o.kind = KIND_RUNNING;
            end else begin
               turn = sched_time + 32'd1 - s.arrived;
               o.kind = KIND_FINISHED;
               o.resp_time = s.resp;
               o.turnaround = turn;
               o.wait_time = turn - 32'(s.total);
            end
         end
         sched_time = sched_time + 32'd1;
      end
      return o;
   endfunction

   task automatic send_item(logic func, logic [7:0] pid, logic [7:0] prio,
                            logic [15:0] burst);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
         @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = func;
      req_tdata  = {burst, prio, pid};
      expected_outcomes.push_back(schedule_item(func, pid, prio, burst));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_random(int arrival_pct);
      if ($urandom_range(99) < arrival_pct)
         send_item(FUNC_ARRIVAL, 8'($urandom), 8'($urandom), $urandom_range(5) == 0 ?
                   16'($urandom) : 16'($urandom_range(6)));
      else
         send_item(FUNC_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   task automatic drain();
      while (expected_outcomes.size() != 0) @(negedge clock);
   endtask

   // receiver
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_tready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_tready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      outcome_type e;
      outcome_type a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a = '{rsp_tuser, rsp_tdata[7:0], rsp_tdata[39:8], rsp_tdata[71:40],
               rsp_tdata[103:72], rsp_tdata[135:104]};
         if (expected_outcomes.size() == 0) begin
            $display("%0t: unexpected item kind %0d id %0d", $time, a.kind, a.ran_id);
            failures++;
         end else begin
            e = expected_outcomes.pop_front();
            if (a != e) begin
               $display("%0t: mismatch expected %p actual %p", $time, e, a);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_off > 0)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic test_directed();
      send_item(FUNC_TICK, 8'h00, 8'h00, 16'h0000);
      send_item(FUNC_ARRIVAL, 8'hff, 8'hff, 16'hffff);
      send_item(FUNC_ARRIVAL, 8'h00, 8'h00, 16'h0000);
      send_item(FUNC_ARRIVAL, 8'h5a, 8'h80, 16'h0001);
      send_item(FUNC_ARRIVAL, 8'ha5, 8'h80, 16'h0002);
      for (int i = 0; i < 6; i++) send_item(FUNC_TICK, 8'hff, 8'hff, 16'hffff);
      for (int i = 0; i < 15; i++) send_item(FUNC_ARRIVAL, 8'(i), 8'h40, 16'h0003);
      send_item(FUNC_ARRIVAL, 8'hee, 8'h01, 16'h0001);
      drain();
   endtask

   task automatic test_random_phase(int idle, int stall, int count);
      send_idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) send_random(ready_count > 12 ? 35 : 55);
      drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      @(negedge clock);
      hold_off <= 300;
      for (int i = 0; i < 40; i++) send_random(50);
      drain();
   endtask

   task automatic test_time_wrap();
      // time does not wrap here; sixteen long jobs fill the heap and keep it busy across the ticks
      send_idle_pct = 0;
      stall_pct = 0;
      for (int i = 0; i < 16; i++) send_item(FUNC_ARRIVAL, 8'(i), 8'($urandom), 16'hffff);
      for (int i = 0; i < 60; i++) send_item(FUNC_TICK, '0, '0, '0);
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_phase(0, 0, 450);
      test_random_phase(57, 0, 400);
      test_backpressure();
      test_random_phase(0, 57, 400);
      test_random_phase(13, 13, 400);
      test_time_wrap();
      repeat (100) @(negedge clock);
      if (failures == 0 && expected_outcomes.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
